// ===== sv/sie_pkg.sv =====
// shared constants, codes and types of the stack ir executor
`timescale 1ns / 1ps
package sie_pkg;

    // storage geometry
    localparam int STACK_DEPTH = 1024;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int MEM_BYTES   = 65536;
    localparam int MADDR_W     = $clog2(MEM_BYTES);
    localparam int ROW_W       = MADDR_W - 2;
    localparam int MEM_ROWS    = MEM_BYTES / 4;
    localparam int NAME_SLOTS  = 256;
    localparam int NAME_W      = $clog2(NAME_SLOTS);
    localparam int CUR_W       = MADDR_W + 1;

    // field widths
    localparam int IP_W   = 16;
    localparam int WORD_W = 32;

    typedef enum logic [3:0] {
        CMD_JUMP_IF  = 4'd0,
        CMD_JUMP     = 4'd1,
        CMD_ALLOC    = 4'd2,
        CMD_STORE    = 4'd3,
        CMD_LOAD     = 4'd4,
        CMD_LABEL    = 4'd5,
        CMD_CALL     = 4'd6,
        CMD_PUSH_INT = 4'd7,
        CMD_PUSH_STR = 4'd8,
        CMD_PLUS     = 4'd9,
        CMD_MULT     = 4'd10,
        CMD_NONE     = 4'd11
    } cmd_t;

    typedef enum logic [2:0] {
        ERR_OK    = 3'd0,
        ERR_OVER  = 3'd1,
        ERR_UNDER = 3'd2,
        ERR_ADDR  = 3'd3,
        ERR_NAME  = 3'd4
    } err_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_STR  = 2'd1,
        KIND_INT  = 2'd2,
        KIND_WARN = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RUN_GO   = 2'd0,
        RUN_END  = 2'd1,
        RUN_HALT = 2'd2
    } status_t;

    localparam logic [1:0] CALL_PUTS = 2'd0;

    // request from the executor to the byte data memory
    typedef struct packed {
        logic               we;
        logic [MADDR_W-1:0] addr;
        logic [WORD_W-1:0]  wdata;
        logic               clr;
        logic [ROW_W-1:0]   clr_row;
    } dmem_req_t;

endpackage

// ===== sv/sie_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module sie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/sie_dmem.sv =====
// byte data memory as four byte lanes, unaligned little-endian word access
`timescale 1ns / 1ps
module sie_dmem (
    input  logic                  aclk,
    input  sie_pkg::dmem_req_t    req,
    output logic [sie_pkg::WORD_W-1:0] rdata
);
    import sie_pkg::*;

    logic [7:0] lane_rd [4];
    logic [1:0] ofs_reg;

    // each lane gets the row holding its byte of the word
    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic [1:0]       bsel;
        logic [MADDR_W-1:0] baddr;
        logic [ROW_W-1:0] row;
        logic             lwe;
        logic [7:0]       lwd;

        assign bsel  = 2'(l) - req.addr[1:0];
        assign baddr = req.addr + MADDR_W'(bsel);
        assign row   = req.clr ? req.clr_row : baddr[MADDR_W-1:2];
        assign lwe   = req.clr | req.we;
        assign lwd   = req.clr ? 8'd0 : req.wdata[8*bsel +: 8];

        sie_ram #(.WIDTH(8), .DEPTH(MEM_ROWS)) u_lane (
            .aclk  (aclk),
            .we    (lwe),
            .waddr (row),
            .wdata (lwd),
            .raddr (row),
            .rdata (lane_rd[l])
        );
    end

    always_ff @(posedge aclk) begin
        ofs_reg <= req.addr[1:0];
    end

    // reassemble the word from the lanes
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            rdata[8*j +: 8] = lane_rd[2'(ofs_reg + 2'(j))];
        end
    end

endmodule

// ===== sv/stack_ir_executor_core.sv =====
// stack ir executor top level: op sequencer, cached top of stack, memories
//
//  channel | ports                 | contents
//  --------+-----------------------+------------------------------------------
//  in      | s_tvalid/s_tready     | s_tuser: cmd; s_tdata: operand, targets
//  out     | m_tvalid/m_tready     | m_tuser: out_kind; m_tdata: ip, value, st
//  config  | cfg_valid/cfg_ready   | cfg_data: program_length
//
// most ops pass an accept state with memory reads (S_IDLE), then an execute
// state (S_EXEC); store with a refill of the top of stack and load also pass
// S_REFILL or S_LOAD, as the stack and data memories have a registered read.
// after reset a clearing pass over all MEM_BYTES/4 = 16384 rows zeroes the data
// memory; no item is taken meanwhile, configuration writes are.
// a result waits in the output register; the next item is taken once that
// register is free or being drained.
`timescale 1ns / 1ps
module stack_ir_executor_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operand[31:0], false_target[47:32], alloc_size[63:48], alloc_name[71:64],
    // call_target[73:72], zero fill
    input  logic [79:0] s_tdata,
    // cmd[3:0]
    input  logic [3:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // next_ip[15:0], out_value[47:16], run_status[49:48], error_code[52:50],
    // zero fill
    output logic [55:0] m_tdata,
    // out_kind[1:0]
    output logic [1:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import sie_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_REFILL, S_LOAD} state_t;

    localparam int SUM_W = CUR_W + 1;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CUR_W-1:0]    cursor_reg, cursor_next;
    logic [IP_W-1:0]     ip_reg, ip_next;
    logic [IP_W-1:0]     plen_reg;
    logic [NAME_SLOTS-1:0] valid_reg, valid_next;
    logic [ROW_W:0]      clr_reg;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [WORD_W-1:0]   tos_reg, tos_next;

    cmd_t                cmd_reg, cmd_next;
    logic [WORD_W-1:0]   opnd_reg, opnd_next;
    logic [IP_W-1:0]     ftgt_reg, ftgt_next;
    logic [15:0]         asize_reg, asize_next;
    logic [NAME_W-1:0]   aname_reg, aname_next;
    logic [1:0]          ctgt_reg, ctgt_next;

    logic [IP_W-1:0]     oip_reg, oip_next;
    kind_t               okind_reg, okind_next;
    logic [WORD_W-1:0]   oval_reg, oval_next;
    status_t             ostat_reg, ostat_next;
    err_t                oerr_reg, oerr_next;

    logic                clearing;
    logic                in_xfer;
    logic                fin;
    logic [IP_W-1:0]     nip;
    kind_t               kind;
    logic [WORD_W-1:0]   val;
    err_t                err;
    logic [CNT_W-1:0]    cnt_m1, cnt_m2, cnt_m3;

    logic                st_we;
    logic [SP_W-1:0]     st_waddr, st_raddr;
    logic [WORD_W-1:0]   st_wdata, st_rdata;
    logic                nt_we;
    logic [CUR_W-1:0]    nt_rdata;
    dmem_req_t           dreq;
    logic [WORD_W-1:0]   d_rdata;

    assign clearing  = !clr_reg[ROW_W];
    assign s_tready  = (state_reg == S_IDLE) && !clearing && (!m_tvalid_reg || m_tready);
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign cnt_m2    = count_reg - CNT_W'(2);
    assign cnt_m3    = count_reg - CNT_W'(3);

    // stack read: second entry on accept, new top after a double pop
    assign st_raddr = (state_reg == S_IDLE) ? cnt_m2[SP_W-1:0] : cnt_m3[SP_W-1:0];

    sie_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    sie_ram #(.WIDTH(CUR_W), .DEPTH(NAME_SLOTS)) u_names (
        .aclk  (aclk),
        .we    (nt_we),
        .waddr (aname_reg),
        .wdata (cursor_reg),
        .raddr (s_tdata[NAME_W-1:0]),
        .rdata (nt_rdata)
    );

    sie_dmem u_dmem (
        .aclk  (aclk),
        .req   (dreq),
        .rdata (d_rdata)
    );

    // op sequencer
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        cursor_next   = cursor_reg;
        ip_next       = ip_reg;
        valid_next    = valid_reg;
        tos_next      = tos_reg;
        cmd_next      = cmd_reg;
        opnd_next     = opnd_reg;
        ftgt_next     = ftgt_reg;
        asize_next    = asize_reg;
        aname_next    = aname_reg;
        ctgt_next     = ctgt_reg;
        oip_next      = oip_reg;
        okind_next    = okind_reg;
        oval_next     = oval_reg;
        ostat_next    = ostat_reg;
        oerr_next     = oerr_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        st_we         = 1'b0;
        st_waddr      = cnt_m1[SP_W-1:0];
        st_wdata      = tos_reg;
        nt_we         = 1'b0;
        dreq          = '0;
        dreq.clr      = clearing;
        dreq.clr_row  = clr_reg[ROW_W-1:0];
        fin           = 1'b0;
        nip           = ip_reg + IP_W'(1);
        kind          = KIND_NONE;
        val           = '0;
        err           = ERR_OK;

        unique case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    cmd_next   = cmd_t'(s_tuser);
                    opnd_next  = s_tdata[31:0];
                    ftgt_next  = s_tdata[47:32];
                    asize_next = s_tdata[63:48];
                    aname_next = s_tdata[71:64];
                    ctgt_next  = s_tdata[73:72];
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                fin        = 1'b1;
                state_next = S_IDLE;
                case (cmd_reg)
                    CMD_JUMP_IF: begin
                        if (count_reg == '0) begin
                            err = ERR_UNDER;
                        end else begin
                            count_next = cnt_m1;
                            tos_next   = st_rdata;
                            if (tos_reg == '0) begin
                                nip = ftgt_reg;
                            end
                        end
                    end
                    CMD_JUMP: begin
                        nip = opnd_reg[IP_W-1:0];
                    end
                    CMD_ALLOC: begin
                        if (count_reg >= CNT_W'(STACK_DEPTH)) begin
                            err = ERR_OVER;
                        end else if (32'(aname_reg) >= 32'(NAME_SLOTS)) begin
                            err = ERR_NAME;
                        end else if ((SUM_W'(cursor_reg) + SUM_W'(asize_reg))
                                     > SUM_W'(MEM_BYTES)) begin
                            err = ERR_ADDR;
                        end else begin
                            st_we                 = count_reg != '0;
                            tos_next              = WORD_W'(cursor_reg);
                            count_next            = count_reg + CNT_W'(1);
                            nt_we                 = 1'b1;
                            valid_next[aname_reg] = 1'b1;
                            cursor_next           = cursor_reg + CUR_W'(asize_reg);
                        end
                    end
                    CMD_STORE: begin
                        if (count_reg < CNT_W'(2)) begin
                            err = ERR_UNDER;
                        end else if (st_rdata > WORD_W'(MEM_BYTES - 4)) begin
                            err = ERR_ADDR;
                        end else begin
                            dreq.we    = 1'b1;
                            dreq.addr  = st_rdata[MADDR_W-1:0];
                            dreq.wdata = tos_reg;
                            count_next = cnt_m2;
                            if (count_reg > CNT_W'(2)) begin
                                fin        = 1'b0;
                                state_next = S_REFILL;
                            end
                        end
                    end
                    CMD_LOAD: begin
                        if (count_reg >= CNT_W'(STACK_DEPTH)) begin
                            err = ERR_OVER;
                        end else if ((opnd_reg[WORD_W-1:NAME_W] != '0) ||
                                     !valid_reg[opnd_reg[NAME_W-1:0]]) begin
                            err = ERR_NAME;
                        end else if (nt_rdata > CUR_W'(MEM_BYTES - 4)) begin
                            err = ERR_ADDR;
                        end else begin
                            dreq.addr  = nt_rdata[MADDR_W-1:0];
                            fin        = 1'b0;
                            state_next = S_LOAD;
                        end
                    end
                    CMD_CALL: begin
                        if (ctgt_reg >= 2'd2) begin
                            kind = KIND_WARN;
                        end else if (count_reg == '0) begin
                            err = ERR_UNDER;
                        end else begin
                            val        = tos_reg;
                            kind       = (ctgt_reg == CALL_PUTS) ? KIND_STR : KIND_INT;
                            count_next = cnt_m1;
                            tos_next   = st_rdata;
                        end
                    end
                    CMD_PUSH_INT, CMD_PUSH_STR: begin
                        if (count_reg >= CNT_W'(STACK_DEPTH)) begin
                            err = ERR_OVER;
                        end else begin
                            st_we      = count_reg != '0;
                            tos_next   = opnd_reg;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    CMD_PLUS, CMD_MULT: begin
                        if (count_reg < CNT_W'(2)) begin
                            err = ERR_UNDER;
                        end else begin
                            tos_next   = (cmd_reg == CMD_PLUS) ? tos_reg + st_rdata
                                                               : tos_reg * st_rdata;
                            count_next = cnt_m1;
                        end
                    end
                    CMD_NONE: begin
                        nip = ip_reg;
                    end
                    default: begin
                    end
                endcase
            end
            S_REFILL: begin
                tos_next   = st_rdata;
                fin        = 1'b1;
                state_next = S_IDLE;
            end
            S_LOAD: begin
                st_we      = count_reg != '0;
                tos_next   = d_rdata;
                count_next = count_reg + CNT_W'(1);
                fin        = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // result into the output register
        if (fin) begin
            ip_next       = nip;
            oip_next      = nip;
            okind_next    = kind;
            oval_next     = val;
            oerr_next     = err;
            m_tvalid_next = 1'b1;
            if (cmd_reg == CMD_NONE) begin
                ostat_next = RUN_HALT;
            end else if (nip >= plen_reg) begin
                ostat_next = RUN_END;
            end else begin
                ostat_next = RUN_GO;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            cursor_reg   <= '0;
            ip_reg       <= '0;
            plen_reg     <= '0;
            valid_reg    <= '0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            cursor_reg   <= cursor_next;
            ip_reg       <= ip_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
            if (clearing) begin
                clr_reg <= clr_reg + (ROW_W+1)'(1);
            end
            if (cfg_valid && cfg_ready) begin
                plen_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        tos_reg   <= tos_next;
        cmd_reg   <= cmd_next;
        opnd_reg  <= opnd_next;
        ftgt_reg  <= ftgt_next;
        asize_reg <= asize_next;
        aname_reg <= aname_next;
        ctgt_reg  <= ctgt_next;
        oip_reg   <= oip_next;
        okind_reg <= okind_next;
        oval_reg  <= oval_next;
        ostat_reg <= ostat_next;
        oerr_reg  <= oerr_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = okind_reg;
    assign m_tdata  = {3'b000, oerr_reg, ostat_reg, oval_reg, oip_reg};

    // stack fill never passes its depth
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // an accepted item is executed in the next cycle
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> (state_reg == S_EXEC))
        else $error("accepted item not executed");

    // no item taken during the memory clearing pass
    a_no_take_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_tready)
        else $error("item taken while clearing");

    // a finished op always finds the output register free
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        fin |-> (!m_tvalid_reg || m_tready))
        else $error("result overwrote a pending one");

endmodule
